@@ src/cgnc_pkg.sv @@
package cgnc_pkg;

  // grid dimensions and derived store geometry
  localparam int MAX_COLS   = 16;
  localparam int MAX_ROWS   = 16;
  localparam int MAX_LAYERS = 16;
  localparam int CELL_TOTAL = MAX_COLS * MAX_ROWS * MAX_LAYERS;
  localparam int AW         = $clog2(CELL_TOTAL);

  // field widths
  localparam int SW     = 5;
  localparam int CRW    = 4;
  localparam int CNTW   = 5;
  localparam int REQW   = 2;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 5;

  // size register reset value before clamping
  localparam int SIZE_RESET = 16;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // request codes
  localparam logic [REQW-1:0] REQ_TOGGLE = 2'd0;
  localparam logic [REQW-1:0] REQ_COUNT  = 2'd1;
  localparam logic [REQW-1:0] REQ_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_COLS   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_ROWS   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_LAYERS = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_WRAP   = 3'd3;

  // per-axis step codes
  localparam logic [1:0] DELTA_DOWN = 2'd0;
  localparam logic [1:0] DELTA_ZERO = 2'd1;
  localparam logic [1:0] DELTA_UP   = 2'd2;

  typedef logic [SW-1:0] size_t;

  typedef struct packed {
    size_t cols;
    size_t rows;
    size_t layers;
    logic  wrap;
  } cfg_t;

  typedef struct packed {
    logic [REQW-1:0] req;
    logic            ok;
    logic [CRW-1:0]  row;
    logic [CRW-1:0]  col;
    logic [CRW-1:0]  layer;
  } item_t;

  typedef struct packed {
    logic  ok;
    size_t pos;
  } step_t;

  // used size: zero acts as one, above the maximum acts as the maximum
  function automatic size_t clamp_size(size_t v, int max_v);
    if (v == '0) return SW'(1);
    if (int'(v) > max_v) return SW'(max_v);
    return v;
  endfunction

  // one axis step, empty or wrapped at the edges
  function automatic step_t step_axis(size_t pos, logic [1:0] delta, size_t size, logic wrap);
    step_t s;
    s.ok  = 1'b1;
    s.pos = pos;
    case (delta)
      DELTA_DOWN: begin
        if (pos == '0) begin
          s.ok  = wrap;
          s.pos = size - SW'(1);
        end else begin
          s.pos = pos - SW'(1);
        end
      end
      DELTA_UP: begin
        if (({1'b0, pos} + (SW+1)'(1)) >= {1'b0, size}) begin
          s.ok  = wrap;
          s.pos = '0;
        end else begin
          s.pos = pos + SW'(1);
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  // store address from coordinates, independent of the used sizes
  function automatic logic [AW-1:0] cell_addr(size_t r, size_t c, size_t l);
    int a;
    a = (int'(l) * MAX_ROWS + int'(r)) * MAX_COLS + int'(c);
    return AW'(a);
  endfunction

endpackage

@@ src/cell_grid_3d_neighbor_counter.sv @@
// 3D grid of one-bit cells with toggle, clear and 26-neighbor count requests.
// A request word is taken when start is high and busy is low; each request gives one
// result, shown for a single cycle with result_valid, and the receiver cannot
// stall it. Requests pass through a two-entry queue to a sequencer that owns a
// single-port cell memory, so cost per request is set by that one memory port:
// a count makes 27 reads of center and neighbors, plus issue and drain steps,
// a toggle or unused code passes the centre and apply states, an out-of-range
// request is answered from idle, and a clear sweeps all MAX_COLS*MAX_ROWS*MAX_LAYERS
// cells, one cell written per cycle. After reset the same sweep clears the memory,
// holding busy high while it runs; configuration writes are taken during that time.
// busy is also high while the queue is full. Configuration must be written only while no
// request is outstanding.
module cell_grid_3d_neighbor_counter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [cgnc_pkg::REQW-1:0]     req_type,
  input  logic [cgnc_pkg::CRW-1:0]      row_index,
  input  logic [cgnc_pkg::CRW-1:0]      col_index,
  input  logic [cgnc_pkg::CRW-1:0]      layer_index,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cgnc_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [cgnc_pkg::CFG_DW-1:0]   cfg_data,
  output logic                          result_valid,
  output logic                          in_range,
  output logic                          cell_value,
  output logic [cgnc_pkg::CNTW-1:0]     neighbor_count
);

  logic            push;
  cgnc_pkg::item_t push_item;
  cgnc_pkg::cfg_t  cfg;
  logic            q_pop;
  cgnc_pkg::item_t q_head;
  logic            q_empty;
  logic            q_full;
  logic            init_busy;

  // stall the command side during the reset sweep or on a full queue
  assign busy      = q_full || init_busy;
  assign cfg_ready = 1'b1;

  cgnc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .row_index   (row_index),
    .col_index   (col_index),
    .layer_index (layer_index),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .push_item   (push_item),
    .cfg         (cfg)
  );

  cgnc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  cgnc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .init_busy      (init_busy),
    .result_valid   (result_valid),
    .in_range       (in_range),
    .cell_value     (cell_value),
    .neighbor_count (neighbor_count)
  );

endmodule

@@ src/cgnc_front.sv @@
module cgnc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [cgnc_pkg::REQW-1:0]     req_type,
  input  logic [cgnc_pkg::CRW-1:0]      row_index,
  input  logic [cgnc_pkg::CRW-1:0]      col_index,
  input  logic [cgnc_pkg::CRW-1:0]      layer_index,
  input  logic                          cfg_valid,
  input  logic [cgnc_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [cgnc_pkg::CFG_DW-1:0]   cfg_data,
  output logic                          push,
  output cgnc_pkg::item_t               push_item,
  output cgnc_pkg::cfg_t                cfg
);

  logic coords_ok;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cols   <= cgnc_pkg::clamp_size(cgnc_pkg::SW'(cgnc_pkg::SIZE_RESET),
                                         cgnc_pkg::MAX_COLS);
      cfg.rows   <= cgnc_pkg::clamp_size(cgnc_pkg::SW'(cgnc_pkg::SIZE_RESET),
                                         cgnc_pkg::MAX_ROWS);
      cfg.layers <= cgnc_pkg::clamp_size(cgnc_pkg::SW'(cgnc_pkg::SIZE_RESET),
                                         cgnc_pkg::MAX_LAYERS);
      cfg.wrap   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        cgnc_pkg::CFG_COLS:   cfg.cols   <= cgnc_pkg::clamp_size(cfg_data, cgnc_pkg::MAX_COLS);
        cgnc_pkg::CFG_ROWS:   cfg.rows   <= cgnc_pkg::clamp_size(cfg_data, cgnc_pkg::MAX_ROWS);
        cgnc_pkg::CFG_LAYERS: cfg.layers <= cgnc_pkg::clamp_size(cfg_data,
                                                                 cgnc_pkg::MAX_LAYERS);
        cgnc_pkg::CFG_WRAP:   cfg.wrap   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // range check and classification of the incoming word
  always_comb begin
    coords_ok = ({1'b0, row_index} < cfg.rows) && ({1'b0, col_index} < cfg.cols) &&
                ({1'b0, layer_index} < cfg.layers);
    push            = start && !busy;
    push_item.req   = req_type;
    push_item.ok    = (req_type == cgnc_pkg::REQ_CLEAR) ? 1'b1 : coords_ok;
    push_item.row   = row_index;
    push_item.col   = col_index;
    push_item.layer = layer_index;
  end

endmodule

@@ src/cgnc_queue.sv @@
module cgnc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cgnc_pkg::item_t push_item,
  input  logic            pop,
  output cgnc_pkg::item_t head,
  output logic            empty,
  output logic            full
);

  cgnc_pkg::item_t              slots [cgnc_pkg::QDEPTH];
  logic [cgnc_pkg::QAW-1:0]     wptr;
  logic [cgnc_pkg::QAW-1:0]     rptr;
  logic [cgnc_pkg::QCW-1:0]     fill;

  assign head  = slots[rptr];
  assign empty = (fill == '0);
  assign full  = (fill == cgnc_pkg::QCW'(cgnc_pkg::QDEPTH));

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == cgnc_pkg::QAW'(cgnc_pkg::QDEPTH - 1)) ? '0 : wptr + cgnc_pkg::QAW'(1);
      end
      if (pop) begin
        rptr <= (rptr == cgnc_pkg::QAW'(cgnc_pkg::QDEPTH - 1)) ? '0 : rptr + cgnc_pkg::QAW'(1);
      end
      if (push && !pop) begin
        fill <= fill + cgnc_pkg::QCW'(1);
      end else if (pop && !push) begin
        fill <= fill - cgnc_pkg::QCW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

endmodule

@@ src/cgnc_back.sv @@
module cgnc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  cgnc_pkg::cfg_t              cfg,
  input  logic                        q_empty,
  input  cgnc_pkg::item_t             q_head,
  output logic                        q_pop,
  output logic                        init_busy,
  output logic                        result_valid,
  output logic                        in_range,
  output logic                        cell_value,
  output logic [cgnc_pkg::CNTW-1:0]   neighbor_count
);

  typedef enum logic [6:0] {
    ST_INIT   = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_CLEAR  = 7'b0000100,
    ST_CENTRE = 7'b0001000,
    ST_APPLY  = 7'b0010000,
    ST_COUNT  = 7'b0100000,
    ST_DRAIN  = 7'b1000000
  } state_t;

  state_t                      state;
  logic [cgnc_pkg::AW-1:0]     clr_addr;
  cgnc_pkg::item_t             cur;
  logic [1:0]                  dr;
  logic [1:0]                  dc;
  logic [1:0]                  dl;
  logic                        pend_valid;
  logic                        pend_centre;
  logic [cgnc_pkg::CNTW-1:0]   cnt;
  logic                        centre_val;

  logic                        mem [cgnc_pkg::CELL_TOTAL];
  logic                        rd_data;
  logic                        mem_we;
  logic                        mem_wd;
  logic [cgnc_pkg::AW-1:0]     mem_addr;

  cgnc_pkg::step_t             nb_r;
  cgnc_pkg::step_t             nb_c;
  cgnc_pkg::step_t             nb_l;
  logic                        nb_ok;
  logic                        is_centre;
  logic                        last_offset;
  logic                        sweep_done;
  logic [cgnc_pkg::AW-1:0]     cur_addr;
  logic [cgnc_pkg::AW-1:0]     nb_addr;
  logic [cgnc_pkg::CNTW-1:0]   cnt_sum;

  assign init_busy = (state == ST_INIT);
  assign q_pop     = (state == ST_IDLE) && !q_empty;

  // neighbor coordinates and memory port selection
  always_comb begin
    nb_r = cgnc_pkg::step_axis({1'b0, cur.row}, dr, cfg.rows, cfg.wrap);
    nb_c = cgnc_pkg::step_axis({1'b0, cur.col}, dc, cfg.cols, cfg.wrap);
    nb_l = cgnc_pkg::step_axis({1'b0, cur.layer}, dl, cfg.layers, cfg.wrap);
    nb_ok       = nb_r.ok && nb_c.ok && nb_l.ok;
    is_centre   = (dr == cgnc_pkg::DELTA_ZERO) && (dc == cgnc_pkg::DELTA_ZERO) &&
                  (dl == cgnc_pkg::DELTA_ZERO);
    last_offset = (dr == cgnc_pkg::DELTA_UP) && (dc == cgnc_pkg::DELTA_UP) &&
                  (dl == cgnc_pkg::DELTA_UP);
    sweep_done  = (clr_addr == cgnc_pkg::AW'(cgnc_pkg::CELL_TOTAL - 1));
    cur_addr    = cgnc_pkg::cell_addr({1'b0, cur.row}, {1'b0, cur.col}, {1'b0, cur.layer});
    nb_addr     = cgnc_pkg::cell_addr(nb_r.pos, nb_c.pos, nb_l.pos);
    cnt_sum     = cnt + cgnc_pkg::CNTW'(pend_valid & rd_data);

    mem_we   = 1'b0;
    mem_wd   = 1'b0;
    mem_addr = cur_addr;
    unique case (state)
      ST_INIT, ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      ST_APPLY: begin
        mem_we = (cur.req == cgnc_pkg::REQ_TOGGLE);
        mem_wd = ~rd_data;
      end
      ST_COUNT: mem_addr = nb_addr;
      default: ;
    endcase
  end

  // single-port cell memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end else begin
      rd_data <= mem[mem_addr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      clr_addr     <= '0;
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
      pend_centre  <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
      pend_centre  <= 1'b0;
      unique case (state)
        ST_INIT: begin
          clr_addr <= clr_addr + cgnc_pkg::AW'(1);
          if (sweep_done) begin
            clr_addr <= '0;
            state    <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!q_empty) begin
            cur <= q_head;
            cnt <= '0;
            dr  <= cgnc_pkg::DELTA_DOWN;
            dc  <= cgnc_pkg::DELTA_DOWN;
            dl  <= cgnc_pkg::DELTA_DOWN;
            if (q_head.req == cgnc_pkg::REQ_CLEAR) begin
              state <= ST_CLEAR;
            end else if (!q_head.ok) begin
              result_valid   <= 1'b1;
              in_range       <= 1'b0;
              cell_value     <= 1'b0;
              neighbor_count <= '0;
            end else if (q_head.req == cgnc_pkg::REQ_COUNT) begin
              state <= ST_COUNT;
            end else begin
              state <= ST_CENTRE;
            end
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + cgnc_pkg::AW'(1);
          if (sweep_done) begin
            clr_addr       <= '0;
            state          <= ST_IDLE;
            result_valid   <= 1'b1;
            in_range       <= 1'b1;
            cell_value     <= 1'b0;
            neighbor_count <= '0;
          end
        end
        ST_CENTRE: state <= ST_APPLY;
        ST_APPLY: begin
          result_valid   <= 1'b1;
          in_range       <= 1'b1;
          cell_value     <= (cur.req == cgnc_pkg::REQ_TOGGLE) ? ~rd_data : rd_data;
          neighbor_count <= '0;
          state          <= ST_IDLE;
        end
        ST_COUNT: begin
          pend_valid  <= nb_ok && !is_centre;
          pend_centre <= is_centre;
          cnt         <= cnt_sum;
          if (pend_centre) begin
            centre_val <= rd_data;
          end
          // walk the 27 offsets, layer fastest
          if (dl == cgnc_pkg::DELTA_UP) begin
            dl <= cgnc_pkg::DELTA_DOWN;
            if (dc == cgnc_pkg::DELTA_UP) begin
              dc <= cgnc_pkg::DELTA_DOWN;
              dr <= dr + 2'd1;
            end else begin
              dc <= dc + 2'd1;
            end
          end else begin
            dl <= dl + 2'd1;
          end
          if (last_offset) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          result_valid   <= 1'b1;
          in_range       <= 1'b1;
          cell_value     <= centre_val;
          neighbor_count <= cnt_sum;
          state          <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ tb/tb_cell_grid_3d_neighbor_counter.sv @@
module tb_cell_grid_3d_neighbor_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import cgnc_pkg::*;

  // request code with no operation behind it
  localparam logic [REQW-1:0] REQ_UNUSED = 2'd3;

  localparam int RANDOM_PHASES    = 12;
  localparam int ITEMS_PER_PHASE  = 88;
  localparam int DRAIN_CYCLES     = 60;

  typedef struct packed {
    logic            ok;
    logic            val;
    logic [CNTW-1:0] cnt;
  } grid_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [REQW-1:0] req_type = '0;
  logic [CRW-1:0] row_index = '0;
  logic [CRW-1:0] col_index = '0;
  logic [CRW-1:0] layer_index = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;
  logic result_valid;
  logic in_range;
  logic cell_value;
  logic [CNTW-1:0] neighbor_count;

  // predictor state: grid copy and effective configuration
  bit grid_bits [CELL_TOTAL];
  int cols_now = MAX_COLS;
  int rows_now = MAX_ROWS;
  int layers_now = MAX_LAYERS;
  bit wrap_now = 1'b0;

  grid_result_t pending_results [$];
  int errors = 0;

  cell_grid_3d_neighbor_counter i_dut (.*);

  always #5 clk = ~clk;

  // run limit
  initial begin
    #10_000_000;
    $display("** cell_grid_3d_neighbor_counter: FAILED **");
    $finish;
  end

  // effective used size of a written register value
  function automatic int used_size(input logic [CFG_DW-1:0] v, input int max_v);
    if (v == '0) return 1;
    if (int'(v) > max_v) return max_v;
    return int'(v);
  endfunction

  // one axis of a neighbor offset, 0 when the neighbor reads empty
  function automatic bit axis_move(input int pos, input int d, input int extent,
                                   output int res);
    res = pos;
    if (d < 0) begin
      if (pos == 0) begin
        res = extent - 1;
        return wrap_now;
      end
      res = pos - 1;
    end else if (d > 0) begin
      if (pos + 1 >= extent) begin
        res = 0;
        return wrap_now;
      end
      res = pos + 1;
    end
    return 1'b1;
  endfunction

  // occupied cells among the 26 neighbors, each wrapped visit counted
  function automatic logic [CNTW-1:0] neighbor_total(input logic [CRW-1:0] r,
                                                     input logic [CRW-1:0] c,
                                                     input logic [CRW-1:0] l);
    int n;
    int nr, nc, nl;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        for (int dl = -1; dl <= 1; dl++) begin
          if (dr == 0 && dc == 0 && dl == 0) continue;
          if (axis_move(int'(r), dr, rows_now, nr) && axis_move(int'(c), dc, cols_now, nc)
              && axis_move(int'(l), dl, layers_now, nl))
            n += grid_bits[{nl[3:0], nr[3:0], nc[3:0]}];
        end
      end
    end
    return CNTW'(n);
  endfunction

  // apply one accepted request to the grid copy and queue its result
  task automatic predict_request(input logic [REQW-1:0] req, input logic [CRW-1:0] r,
                                 input logic [CRW-1:0] c, input logic [CRW-1:0] l);
    grid_result_t res;
    bit ok;
    ok = int'(r) < rows_now && int'(c) < cols_now && int'(l) < layers_now;
    res = '0;
    if (req == REQ_CLEAR) begin
      foreach (grid_bits[i]) grid_bits[i] = 1'b0;
      res.ok = 1'b1;
    end else if (ok) begin
      if (req == REQ_TOGGLE) grid_bits[{l, r, c}] = ~grid_bits[{l, r, c}];
      else if (req == REQ_COUNT) res.cnt = neighbor_total(r, c, l);
      res.val = grid_bits[{l, r, c}];
      res.ok = 1'b1;
    end
    pending_results.push_back(res);
  endtask

  // send one request word, with an optional idle gap before it
  task automatic send_request(input logic [REQW-1:0] req, input logic [CRW-1:0] r,
                              input logic [CRW-1:0] c, input logic [CRW-1:0] l,
                              input int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= req;
    row_index <= r;
    col_index <= c;
    layer_index <= l;
    do @(posedge clk); while (busy);
    predict_request(req, r, c, l);
  endtask

  task automatic end_requests();
    start <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one register write word; the caller lowers valid after a group
  task automatic write_reg(input logic [CFG_IW-1:0] index, input logic [CFG_DW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      CFG_COLS:   cols_now = used_size(data, MAX_COLS);
      CFG_ROWS:   rows_now = used_size(data, MAX_ROWS);
      CFG_LAYERS: layers_now = used_size(data, MAX_LAYERS);
      CFG_WRAP:   wrap_now = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [CFG_DW-1:0] cols, input logic [CFG_DW-1:0] rows,
                              input logic [CFG_DW-1:0] layers, input logic [CFG_DW-1:0] wrap);
    write_reg(CFG_COLS, cols);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_LAYERS, layers);
    write_reg(CFG_WRAP, wrap);
    cfg_valid <= 1'b0;
  endtask

  // random used size, extremes and out-of-range codes included
  function automatic logic [CFG_DW-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd2;
      3, 4, 5, 6: return CFG_DW'($urandom_range(3, 6));
      7: return 5'd16;
      8: return CFG_DW'($urandom_range(17, 31));
      default: return CFG_DW'($urandom_range(1, 16));
    endcase
  endfunction

  // coordinate mostly in range and clustered so cells have neighbors
  function automatic logic [CRW-1:0] pick_coord(input int extent);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return CRW'($urandom_range(0, 15));
    if (extent > 4 && roll < 50) return CRW'($urandom_range(0, 3));
    return CRW'($urandom_range(0, extent - 1));
  endfunction

  // far corners at full size, with and without wrap
  task automatic test_corner_cells();
    apply_config(5'd16, 5'd16, 5'd16, 5'd0);
    send_request(REQ_TOGGLE, 4'd0, 4'd0, 4'd0, 0);
    send_request(REQ_TOGGLE, 4'd15, 4'd15, 4'd15, 0);
    send_request(REQ_TOGGLE, 4'd1, 4'd1, 4'd1, 0);
    send_request(REQ_COUNT, 4'd0, 4'd0, 4'd0, 0);
    send_request(REQ_COUNT, 4'd15, 4'd15, 4'd15, 0);
    send_request(REQ_COUNT, 4'd14, 4'd14, 4'd14, 0);
    end_requests();
    wait_drained();
    apply_config(5'd16, 5'd16, 5'd16, 5'd1);
    send_request(REQ_COUNT, 4'd0, 4'd0, 4'd0, 0);
    send_request(REQ_COUNT, 4'd15, 4'd15, 4'd15, 0);
    end_requests();
    wait_drained();
  endtask

  // zero and oversized used sizes, requests outside and inside them
  task automatic test_out_of_range();
    apply_config(5'd0, 5'd31, 5'd3, 5'd0);
    send_request(REQ_TOGGLE, 4'd0, 4'd0, 4'd5, 0);
    send_request(REQ_COUNT, 4'd0, 4'd3, 4'd0, 0);
    send_request(REQ_TOGGLE, 4'd0, 4'd0, 4'd0, 0);
    end_requests();
    wait_drained();
  endtask

  // code 3 in and out of range
  task automatic test_unused_code();
    apply_config(5'd16, 5'd16, 5'd3, 5'd0);
    send_request(REQ_UNUSED, 4'd1, 4'd1, 4'd1, 0);
    send_request(REQ_UNUSED, 4'd15, 4'd0, 4'd15, 0);
    end_requests();
    wait_drained();
  endtask

  // clear with out-of-range coordinates, then read back
  task automatic test_clear();
    send_request(REQ_CLEAR, 4'd15, 4'd15, 4'd15, 0);
    send_request(REQ_COUNT, 4'd1, 4'd1, 4'd1, 0);
    end_requests();
    wait_drained();
  endtask

  // torus of size one and two, wrapped visits landing on the same cells, then without wrap
  task automatic test_small_torus();
    apply_config(5'd1, 5'd2, 5'd2, 5'd1);
    send_request(REQ_TOGGLE, 4'd0, 4'd0, 4'd0, 0);
    send_request(REQ_TOGGLE, 4'd1, 4'd0, 4'd1, 0);
    send_request(REQ_COUNT, 4'd0, 4'd0, 4'd0, 0);
    send_request(REQ_COUNT, 4'd1, 4'd0, 4'd1, 0);
    end_requests();
    wait_drained();
    apply_config(5'd1, 5'd2, 5'd2, 5'd0);
    send_request(REQ_COUNT, 4'd0, 4'd0, 4'd0, 0);
    end_requests();
    wait_drained();
  endtask

  // random phases, each with its own sizes, wrap and sender idling
  task automatic test_random_phases();
    int idle_pct;
    int pick;
    logic [REQW-1:0] req;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_config(pick_size(), pick_size(), pick_size(), CFG_DW'($urandom_range(0, 31)));
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 54;
        default: idle_pct = 31;
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        pick = $urandom_range(0, 199);
        if (pick < 4) req = REQ_CLEAR;
        else if (pick < 14) req = REQ_UNUSED;
        else if (pick < 104) req = REQ_TOGGLE;
        else req = REQ_COUNT;
        send_request(req, pick_coord(rows_now), pick_coord(cols_now),
                     pick_coord(layers_now), idle_pct);
      end
      end_requests();
      wait_drained();
    end
  endtask

  // result check against the oldest expectation
  always @(posedge clk) begin : result_check
    grid_result_t exp_r;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: in_range %0d cell_value %0d count %0d",
                 $time, in_range, cell_value, neighbor_count);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (in_range !== exp_r.ok) begin
          $display("%0t: in_range expected %0d actual %0d", $time, exp_r.ok, in_range);
          errors++;
        end
        if (cell_value !== exp_r.val) begin
          $display("%0t: cell_value expected %0d actual %0d", $time, exp_r.val, cell_value);
          errors++;
        end
        if (neighbor_count !== exp_r.cnt) begin
          $display("%0t: neighbor_count expected %0d actual %0d", $time, exp_r.cnt,
                   neighbor_count);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_cells();
    test_out_of_range();
    test_unused_code();
    test_clear();
    test_small_torus();
    test_random_phases();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** cell_grid_3d_neighbor_counter: PASSED **");
    end else begin
      $display("** cell_grid_3d_neighbor_counter: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/cgnc_pkg.sv
src/cgnc_front.sv
src/cgnc_queue.sv
src/cgnc_back.sv
src/cell_grid_3d_neighbor_counter.sv
tb/tb_cell_grid_3d_neighbor_counter.sv
